[rtl/core/kst_pkg.sv]
// ----------------------------------------------------------------------------
// kst_pkg: shared types and constants of the scan code translator
// Request codes, scan code constants, navigation tables and the structs
// that pass between the translator, the key ring and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package kst_pkg;

  localparam int RING_SLOTS_DEF = 16;

  typedef enum logic [1:0] {
    REQ_SCAN   = 2'd0,
    REQ_TAKE   = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_INSERT = 2'd3
  } req_t;

  // Modifier scan codes, matched with the break bit ignored
  localparam logic [6:0] SC_LSHIFT = 7'h2A;
  localparam logic [6:0] SC_RSHIFT = 7'h36;
  localparam logic [6:0] SC_CTRL   = 7'h1D;
  localparam logic [6:0] SC_ALT    = 7'h38;

  localparam logic [3:0] MOD_RSHIFT = 4'h1;
  localparam logic [3:0] MOD_LSHIFT = 4'h2;
  localparam logic [3:0] MOD_CTRL   = 4'h4;
  localparam logic [3:0] MOD_ALT    = 4'h8;

  localparam logic [7:0] SC_ESC    = 8'h01;
  localparam logic [7:0] SC_DIG_LO = 8'h02;
  localparam logic [7:0] SC_DIG_HI = 8'h0D;
  localparam logic [7:0] SC_BKSP   = 8'h0E;
  localparam logic [7:0] SC_TAB    = 8'h0F;
  localparam logic [7:0] SC_ENTER  = 8'h1C;
  localparam logic [7:0] SC_F1     = 8'h3B;
  localparam logic [7:0] SC_F10    = 8'h44;
  localparam logic [7:0] SC_NAV_LO = 8'h47;
  localparam logic [7:0] SC_NAV_HI = 8'h53;
  localparam logic [7:0] SC_KP_MIN = 8'h4A;
  localparam logic [7:0] SC_KP_5   = 8'h4C;
  localparam logic [7:0] SC_KP_PLS = 8'h4E;
  localparam logic [7:0] SC_F11    = 8'h57;
  localparam logic [7:0] SC_F12    = 8'h58;

  // Function key offsets
  localparam logic [7:0] FK_ALT_OFS   = 8'h2D;
  localparam logic [7:0] FK_CTRL_OFS  = 8'h23;
  localparam logic [7:0] FK_SHIFT_OFS = 8'h19;
  localparam logic [7:0] F11_BASE     = 8'h85;
  localparam logic [7:0] F11_ALT_OFS   = 8'h06;
  localparam logic [7:0] F11_CTRL_OFS  = 8'h04;
  localparam logic [7:0] F11_SHIFT_OFS = 8'h02;

  localparam logic [7:0] TAB_ALT    = 8'hA5;
  localparam logic [7:0] TAB_CTRL   = 8'h94;
  localparam logic [7:0] ENTER_ALT  = 8'hA6;
  localparam logic [7:0] ASC_DEL    = 8'h7F;
  localparam logic [7:0] ASC_LF     = 8'h0A;
  localparam logic [7:0] ALT_DIG_BASE = 8'h78;

  function automatic logic [7:0] nav_ctrl(input logic [3:0] idx);
    logic [7:0] v;
    unique case (idx)
      4'd0:  v = 8'h77;
      4'd1:  v = 8'h8D;
      4'd2:  v = 8'h84;
      4'd4:  v = 8'h73;
      4'd5:  v = 8'h8F;
      4'd6:  v = 8'h74;
      4'd8:  v = 8'h75;
      4'd9:  v = 8'h91;
      4'd10: v = 8'h76;
      4'd11: v = 8'h92;
      4'd12: v = 8'h93;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] nav_alt(input logic [3:0] idx);
    logic [7:0] v;
    unique case (idx)
      4'd0:  v = 8'h97;
      4'd1:  v = 8'h98;
      4'd2:  v = 8'h99;
      4'd4:  v = 8'h9B;
      4'd6:  v = 8'h9D;
      4'd8:  v = 8'h9F;
      4'd9:  v = 8'hA0;
      4'd10: v = 8'hA1;
      4'd11: v = 8'hA2;
      4'd12: v = 8'hA3;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic        put;
    logic [15:0] word;
    logic [3:0]  shift_nxt;
  } xlate_t;

  typedef struct packed {
    logic        wr_en;
    logic [15:0] wr_data;
    logic        rd_adv;
  } ring_cmd_t;

  typedef struct packed {
    logic        empty;
    logic        full;
    logic [15:0] head;
  } ring_stat_t;

endpackage

`default_nettype wire

[rtl/core/kst_if.sv]
// ----------------------------------------------------------------------------
// kst_if: request and result channels of the scan code translator
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface kst_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] scan_code;
  logic [7:0] ascii_code;

  modport source (output valid, output req_type, output scan_code, output ascii_code,
                  input ready);
  modport sink   (input valid, input req_type, input scan_code, input ascii_code,
                  output ready);
endinterface

interface kst_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] key_word;
  logic        key_valid;
  logic        stored;
  logic [3:0]  modifier_flags;

  modport source (output valid, output key_word, output key_valid, output stored,
                  output modifier_flags, input ready);
  modport sink   (input valid, input key_word, input key_valid, input stored,
                  input modifier_flags, output ready);
endinterface

`default_nettype wire

[rtl/core/keyboard_scancode_translator_ring.sv]
// ----------------------------------------------------------------------------
// keyboard_scancode_translator_ring: PC keyboard scan code translator
// Turns scan codes into BIOS key words held in a ring buffer; take, peek
// and direct insert requests share the same request channel.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one request per beat: req_type (scan event, take, peek,
//          insert), scan_code and ascii_code.
//   out_ch returns exactly one result beat per request: key_word and
//          key_valid for take/peek, stored when a word entered the ring,
//          and modifier_flags after the request.
//   A request beat lands in the input register, is translated and applied
//   to the ring, and its result is held in the result register for out_ch.
//   Throughput is one request per cycle unless out_ch stalls; the ring has
//   one write port and a registered head word, and every request touches
//   it at most once.
//   Reset clears the modifier register and the ring indices; the ring is
//   empty, so its storage needs no clearing.
//   When the receiver stalls, the result register holds its beat, the
//   input register holds one more request, and in_ch.ready drops after
//   that. Holds RING_SLOTS-1 words; a word for a full ring is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_scancode_translator_ring
  import kst_pkg::*;
#(
  parameter int RING_SLOTS = RING_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  kst_in_if.sink      in_ch,
  kst_out_if.source   out_ch
);

  // Input register
  logic       in_v_r;
  req_t       req_r;
  logic [7:0] scan_r;
  logic [7:0] ascii_r;

  // Modifier register
  logic [3:0] shift_r;

  // Result register
  logic        out_v_r;
  logic [15:0] key_word_r;
  logic        key_valid_r;
  logic        stored_r;
  logic [3:0]  mods_r;

  logic       adv;
  logic       proc;
  logic       in_beat;
  logic       is_read;
  xlate_t     xo;
  ring_cmd_t  rcmd;
  ring_stat_t rstat;

  // Advance the input register whenever the result register can take a beat
  assign adv     = !out_v_r || out_ch.ready;
  assign proc    = in_v_r && adv;
  assign in_ch.ready = !in_v_r || adv;
  assign in_beat = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_beat) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      req_r   <= req_t'(in_ch.req_type);
      scan_r  <= in_ch.scan_code;
      ascii_r <= in_ch.ascii_code;
    end
  end

  kst_xlate u_xlate (
    .req       (req_r),
    .scan      (scan_r),
    .ascii     (ascii_r),
    .shift_cur (shift_r),
    .xo        (xo)
  );

  // Drop the word when the ring is full; advance the head only on a take
  assign is_read      = (req_r == REQ_TAKE) || (req_r == REQ_PEEK);
  assign rcmd.wr_en   = proc && xo.put && !rstat.full;
  assign rcmd.wr_data = xo.word;
  assign rcmd.rd_adv  = proc && (req_r == REQ_TAKE) && !rstat.empty;

  kst_ring #(
    .RING_SLOTS (RING_SLOTS)
  ) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (rcmd),
    .stat  (rstat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 4'h0;
    end else if (proc) begin
      shift_r <= xo.shift_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      key_word_r  <= (is_read && !rstat.empty) ? rstat.head : 16'h0000;
      key_valid_r <= is_read && !rstat.empty;
      stored_r    <= xo.put && !rstat.full;
      mods_r      <= xo.shift_nxt;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.key_word       = key_word_r;
  assign out_ch.key_valid      = key_valid_r;
  assign out_ch.stored         = stored_r;
  assign out_ch.modifier_flags = mods_r;

  // A beat either reads the ring or writes it, never both
  a_no_read_and_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(key_valid_r && stored_r))
    else $error("result both read and stored a key word");

  // A miss reports a zero key word
  a_miss_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !key_valid_r) |-> (key_word_r == 16'h0000))
    else $error("key word nonzero without a key");

  // The ring can never look empty and full at once
  a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(rstat.empty && rstat.full))
    else $error("ring empty and full together");

  // A write into a full ring never happens
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && xo.put && rstat.full) |=> !stored_r)
    else $error("word stored into a full ring");

endmodule

`default_nettype wire

[rtl/core/kst_xlate.sv]
// ----------------------------------------------------------------------------
// kst_xlate: scan code to key word translation
// Combinational: modifier update and the key word to enqueue, if any.
// ----------------------------------------------------------------------------
`default_nettype none

module kst_xlate
  import kst_pkg::*;
(
  input  req_t       req,
  input  logic [7:0] scan,
  input  logic [7:0] ascii,
  input  logic [3:0] shift_cur,
  output xlate_t     xo
);

  always_comb begin
    logic [3:0] mod_bit;
    logic       down;
    logic       alt;
    logic       ctrl;
    logic       shf;
    logic       nav_rng;
    logic [7:0] nav_ofs;
    logic [7:0] nav_x;
    logic [7:0] fk_m;
    logic [7:0] f11_m;

    down    = !scan[7];
    alt     = shift_cur[3];
    ctrl    = shift_cur[2];
    shf     = |shift_cur[1:0];
    nav_rng = (scan >= SC_NAV_LO) && (scan <= SC_NAV_HI);
    nav_ofs = scan - SC_NAV_LO;
    nav_x   = alt ? nav_alt(nav_ofs[3:0]) : nav_ctrl(nav_ofs[3:0]);
    fk_m    = alt ? FK_ALT_OFS : ctrl ? FK_CTRL_OFS : shf ? FK_SHIFT_OFS : 8'h00;
    f11_m   = alt ? F11_ALT_OFS : ctrl ? F11_CTRL_OFS : shf ? F11_SHIFT_OFS : 8'h00;

    unique case (scan[6:0])
      SC_LSHIFT: mod_bit = MOD_LSHIFT;
      SC_RSHIFT: mod_bit = MOD_RSHIFT;
      SC_CTRL:   mod_bit = MOD_CTRL;
      SC_ALT:    mod_bit = MOD_ALT;
      default:   mod_bit = 4'h0;
    endcase

    xo.put       = 1'b0;
    xo.word      = 16'h0000;
    xo.shift_nxt = shift_cur;

    unique case (req)
      REQ_INSERT: begin
        xo.put  = 1'b1;
        xo.word = {scan, ascii};
      end
      REQ_TAKE, REQ_PEEK: begin
        xo.put = 1'b0;
      end
      REQ_SCAN: begin
        if (mod_bit != 4'h0) begin
          xo.shift_nxt = down ? (shift_cur | mod_bit) : (shift_cur & ~mod_bit);
        end else if (down) begin
          priority if ((scan >= SC_F1) && (scan <= SC_F10)) begin
            xo.put  = 1'b1;
            xo.word = {scan + fk_m, 8'h00};
          end else if ((scan == SC_F11) || (scan == SC_F12)) begin
            xo.put  = 1'b1;
            xo.word = {F11_BASE + {7'd0, scan == SC_F12} + f11_m, 8'h00};
          end else if (nav_rng && (scan != SC_KP_MIN) && (scan != SC_KP_5) &&
                       (scan != SC_KP_PLS) && (ctrl || alt) && (nav_x != 8'h00)) begin
            xo.put  = 1'b1;
            xo.word = {nav_x, 8'h00};
          end else if ((scan == SC_TAB) && (shf || ctrl || alt)) begin
            xo.put  = 1'b1;
            xo.word = {alt ? TAB_ALT : ctrl ? TAB_CTRL : SC_TAB, 8'h00};
          end else if ((scan == SC_BKSP) && (ctrl || alt)) begin
            xo.put  = 1'b1;
            xo.word = {SC_BKSP, alt ? 8'h00 : ASC_DEL};
          end else if ((scan == SC_ENTER) && (ctrl || alt)) begin
            xo.put  = 1'b1;
            xo.word = {alt ? ENTER_ALT : SC_ENTER, alt ? 8'h00 : ASC_LF};
          end else if (alt && (scan >= SC_DIG_LO) && (scan <= SC_DIG_HI)) begin
            xo.put  = 1'b1;
            xo.word = {ALT_DIG_BASE + (scan - SC_DIG_LO), 8'h00};
          end else if (alt) begin
            xo.put  = 1'b1;
            xo.word = {scan, 8'h00};
          end else if ((ascii == 8'h00) && !nav_rng && (scan != SC_ESC)) begin
            xo.put = 1'b0;
          end else begin
            xo.put  = 1'b1;
            xo.word = {scan, ascii};
          end
        end
      end
      default: begin
        xo.put = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/kst_ring.sv]
// ----------------------------------------------------------------------------
// kst_ring: key word ring buffer
// One write and one registered read per cycle; the head word register
// follows the read index and forwards a write into the head slot.
// ----------------------------------------------------------------------------
`default_nettype none

module kst_ring
  import kst_pkg::*;
#(
  parameter int RING_SLOTS = RING_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ring_cmd_t  cmd,
  output ring_stat_t stat
);

  localparam int IDX_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(RING_SLOTS - 1);

  logic [15:0]      mem [RING_SLOTS];
  logic [IDX_W-1:0] wr_r, wr_nxt;
  logic [IDX_W-1:0] rd_r, rd_nxt;
  logic [IDX_W-1:0] wr_inc, rd_inc;
  logic [15:0]      head_r;

  assign wr_inc = (wr_r == LAST) ? '0 : wr_r + 1'b1;
  assign rd_inc = (rd_r == LAST) ? '0 : rd_r + 1'b1;

  assign wr_nxt = cmd.wr_en  ? wr_inc : wr_r;
  assign rd_nxt = cmd.rd_adv ? rd_inc : rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_r] <= cmd.wr_data;
    end
  end

  // Track the slot at the next read index; forward a write landing there
  always_ff @(posedge clk) begin
    if (cmd.wr_en && (wr_r == rd_nxt)) begin
      head_r <= cmd.wr_data;
    end else begin
      head_r <= mem[rd_nxt];
    end
  end

  assign stat.empty = (rd_r == wr_r);
  assign stat.full  = (wr_inc == rd_r);
  assign stat.head  = head_r;

endmodule

`default_nettype wire

[tb/kst_key_checker.sv]
// ----------------------------------------------------------------------------
// kst_key_checker: key word predictor and result checker
// Watches the request and result channels of the scan code translator,
// predicts one result per accepted request and compares every result beat
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module kst_key_checker
  import kst_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  kst_in_if    in_ch,
  kst_out_if   out_ch,
  output int   fail_count,
  output int   outstanding,
  output int   checked_count,
  output int   stored_count,
  output int   drop_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = RING_SLOTS_DEF;

  // Ctrl and Alt codes for the navigation block, indexed from Home (0x47)
  localparam logic [7:0] NAV_CTRL_CODES [13] = '{
    8'h77, 8'h8D, 8'h84, 8'h00, 8'h73, 8'h8F, 8'h74,
    8'h00, 8'h75, 8'h91, 8'h76, 8'h92, 8'h93
  };
  localparam logic [7:0] NAV_ALT_CODES [13] = '{
    8'h97, 8'h98, 8'h99, 8'h00, 8'h9B, 8'h00, 8'h9D,
    8'h00, 8'h9F, 8'hA0, 8'hA1, 8'hA2, 8'hA3
  };

  typedef struct packed {
    logic [15:0] key_word;
    logic        key_valid;
    logic        stored;
    logic [3:0]  flags;
  } key_result_t;

  logic [3:0]  held_mods;
  logic [15:0] ring_words [SLOTS];
  int          head_idx;
  int          tail_idx;
  key_result_t key_results_due [$];
  key_result_t due;

  initial begin
    fail_count    = 0;
    outstanding   = 0;
    checked_count = 0;
    stored_count  = 0;
    drop_count    = 0;
  end

  // Append a word unless that would make the ring look empty
  function automatic logic ring_push(input logic [7:0] scan, input logic [7:0] ascii);
    int nxt;
    nxt = (tail_idx + 1) % SLOTS;
    if (nxt == head_idx) begin
      drop_count++;
      return 1'b0;
    end
    ring_words[tail_idx] = {scan, ascii};
    tail_idx = nxt;
    return 1'b1;
  endfunction

  function automatic logic translate_scan(input logic [7:0] code, input logic [7:0] ascii);
    logic [3:0] mod_bit;
    logic       alt;
    logic       ctrl;
    logic       shf;
    logic       in_nav;
    logic [7:0] ofs;
    logic [7:0] nav;
    mod_bit = 4'h0;
    case (code[6:0])
      SC_LSHIFT: mod_bit = MOD_LSHIFT;
      SC_RSHIFT: mod_bit = MOD_RSHIFT;
      SC_CTRL:   mod_bit = MOD_CTRL;
      SC_ALT:    mod_bit = MOD_ALT;
      default:   mod_bit = 4'h0;
    endcase
    if (mod_bit != 4'h0) begin
      if (!code[7]) held_mods = held_mods | mod_bit;
      else held_mods = held_mods & ~mod_bit;
      return 1'b0;
    end
    // drop break codes and the extended prefix
    if (code[7]) return 1'b0;

    alt    = (held_mods & MOD_ALT) != 4'h0;
    ctrl   = (held_mods & MOD_CTRL) != 4'h0;
    shf    = (held_mods & (MOD_LSHIFT | MOD_RSHIFT)) != 4'h0;
    in_nav = code >= SC_NAV_LO && code <= SC_NAV_HI;

    if (code >= SC_F1 && code <= SC_F10) begin
      ofs = alt ? FK_ALT_OFS : ctrl ? FK_CTRL_OFS : shf ? FK_SHIFT_OFS : 8'h00;
      return ring_push(code + ofs, 8'h00);
    end
    if (code == SC_F11 || code == SC_F12) begin
      ofs = alt ? F11_ALT_OFS : ctrl ? F11_CTRL_OFS : shf ? F11_SHIFT_OFS : 8'h00;
      return ring_push(F11_BASE + (code - SC_F11) + ofs, 8'h00);
    end
    if (in_nav && code != SC_KP_MIN && code != SC_KP_5 && code != SC_KP_PLS
        && (ctrl || alt)) begin
      nav = alt ? NAV_ALT_CODES[code - SC_NAV_LO] : NAV_CTRL_CODES[code - SC_NAV_LO];
      // table holes fall through to the generic handling
      if (nav != 8'h00) return ring_push(nav, 8'h00);
    end
    if (code == SC_TAB && (shf || ctrl || alt))
      return ring_push(alt ? TAB_ALT : ctrl ? TAB_CTRL : SC_TAB, 8'h00);
    if (code == SC_BKSP && (ctrl || alt))
      return ring_push(SC_BKSP, alt ? 8'h00 : ASC_DEL);
    if (code == SC_ENTER && (ctrl || alt))
      return ring_push(alt ? ENTER_ALT : SC_ENTER, alt ? 8'h00 : ASC_LF);
    if (alt && code >= SC_DIG_LO && code <= SC_DIG_HI)
      return ring_push(ALT_DIG_BASE + (code - SC_DIG_LO), 8'h00);
    if (alt)
      return ring_push(code, 8'h00);
    if (ascii == 8'h00 && !in_nav && code != SC_ESC)
      return 1'b0;
    return ring_push(code, ascii);
  endfunction

  function automatic key_result_t predict_key_result(input logic [1:0] req,
                                                     input logic [7:0] scan,
                                                     input logic [7:0] ascii);
    key_result_t r;
    r = '0;
    case (req_t'(req))
      REQ_SCAN:   r.stored = translate_scan(scan, ascii);
      REQ_INSERT: r.stored = ring_push(scan, ascii);
      REQ_TAKE, REQ_PEEK: begin
        if (head_idx != tail_idx) begin
          r.key_word  = ring_words[head_idx];
          r.key_valid = 1'b1;
          if (req_t'(req) == REQ_TAKE) head_idx = (head_idx + 1) % SLOTS;
        end
      end
      default: r = '0;
    endcase
    if (r.stored) stored_count++;
    r.flags = held_mods;
    return r;
  endfunction

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] seen);
    if (want !== seen) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, seen);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_mods = 4'h0;
      head_idx  = 0;
      tail_idx  = 0;
      key_results_due.delete();
      outstanding = 0;
    end else begin
      // retire first: a result can never belong to a request of this edge
      if (out_ch.valid && out_ch.ready) begin
        if (key_results_due.size() == 0) begin
          fail_count++;
          $display("%0t ns: unexpected result, expected none, actual word %h valid %b stored %b flags %h",
                   $time, out_ch.key_word, out_ch.key_valid, out_ch.stored,
                   out_ch.modifier_flags);
        end else begin
          due = key_results_due.pop_front();
          report_field("key_word", due.key_word, out_ch.key_word);
          report_field("key_valid", 16'(due.key_valid), 16'(out_ch.key_valid));
          report_field("stored", 16'(due.stored), 16'(out_ch.stored));
          report_field("modifier_flags", 16'(due.flags), 16'(out_ch.modifier_flags));
          checked_count++;
        end
      end
      if (in_ch.valid && in_ch.ready)
        key_results_due.push_back(predict_key_result(in_ch.req_type, in_ch.scan_code,
                                                     in_ch.ascii_code));
      outstanding = key_results_due.size();
    end
  end

endmodule

`default_nettype wire

[tb/keyboard_scancode_translator_ring_tb.sv]
// ----------------------------------------------------------------------------
// keyboard_scancode_translator_ring_tb: top level of the translator bench
// Drives scan code, take, peek and insert requests through the request
// channel with bursty timing and a stalling result sink; the checker beside
// the block predicts every result and this module reports the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module keyboard_scancode_translator_ring_tb;
  import kst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET    = 1450;
  localparam int LONG_HOLD      = 80;    // cycles of the long sink hold-off
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no beat at all
  localparam int LATENCY_TAIL   = 8;     // tail after the drain, longer than the block's latency

  localparam logic [7:0] EXT_PREFIX = 8'hE0;

  // Modifier keys in flag bit order: right shift, left shift, ctrl, alt
  localparam logic [6:0] MOD_KEYS [4] = '{SC_RSHIFT, SC_LSHIFT, SC_CTRL, SC_ALT};

  // Opening sequence: {request, scan byte, ascii byte}. Walks the empty
  // ring, both insert extremes, the shift, ctrl and alt paths and the special keys,
  // and ends by overfilling the ring so the last key word gets dropped.
  localparam int OPENING_LEN = 29;
  localparam logic [17:0] OPENING_SEQ [OPENING_LEN] = '{
    {REQ_TAKE,   8'h00,              8'h00},  // take from empty ring
    {REQ_PEEK,   8'hFF,              8'hFF},  // peek at empty ring
    {REQ_INSERT, 8'hFF,              8'hFF},
    {REQ_INSERT, 8'h00,              8'h00},
    {REQ_TAKE,   8'hFF,              8'hFF},
    {REQ_SCAN,   8'h1E,              8'h00},  // plain key without ascii: dropped
    {REQ_SCAN,   SC_ESC,             8'h00},  // Esc survives ascii 0
    {REQ_SCAN,   SC_NAV_LO,          8'h00},  // so does Home
    {REQ_SCAN,   EXT_PREFIX,         8'h00},  // extended prefix: ignored
    {REQ_SCAN,   {1'b0, SC_LSHIFT},  8'h00},
    {REQ_SCAN,   SC_F1,              8'h00},  // shifted F1
    {REQ_SCAN,   SC_TAB,             8'h09},  // back tab
    {REQ_SCAN,   SC_F11,             8'h00},
    {REQ_SCAN,   {1'b1, SC_LSHIFT},  8'h00},
    {REQ_SCAN,   {1'b0, SC_CTRL},    8'h00},
    {REQ_SCAN,   SC_F10,             8'h00},
    {REQ_SCAN,   SC_BKSP,            8'h08},
    {REQ_SCAN,   SC_ENTER,           8'h0D},
    {REQ_SCAN,   8'h4B,              8'h34},  // ctrl cursor left
    {REQ_SCAN,   SC_KP_MIN,          8'h2D},  // keypad minus keeps its ascii
    {REQ_SCAN,   {1'b0, SC_ALT},     8'h00},
    {REQ_SCAN,   SC_DIG_HI,          8'h3D},  // alt number row
    {REQ_SCAN,   SC_KP_5,            8'h35},  // alt keypad 5: no table entry
    {REQ_SCAN,   {1'b1, SC_CTRL},    8'h00},
    {REQ_SCAN,   SC_F12,             8'h00},
    {REQ_SCAN,   SC_NAV_HI,          8'h2E},  // fifteenth word fills the ring
    {REQ_SCAN,   SC_ENTER,           8'h0D},  // ring full: dropped
    {REQ_SCAN,   8'hFF,              8'hFF},  // break with every bit set
    {REQ_SCAN,   {1'b1, SC_ALT},     8'h00}
  };

  typedef enum int {MIX_TYPING, MIX_FILL, MIX_DRAIN, MIX_NOISE} traffic_mix_t;
  typedef enum int {SINK_OPEN, SINK_SPARSE, SINK_COIN, SINK_RHYTHM} sink_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic long_hold_req;

  int fail_count;
  int outstanding;
  int checked_count;
  int stored_count;
  int drop_count;

  int sent_total;
  int sent_by_req [4];
  int burst_left;
  logic gaps_on;
  int idle_cycles;

  kst_in_if  in_ch ();
  kst_out_if out_ch ();

  keyboard_scancode_translator_ring u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  kst_key_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count),
    .stored_count  (stored_count),
    .drop_count    (drop_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: end the run when neither channel moves a beat for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result sink: switch between stall patterns every so often, and hold ready low
  // through the LONG_HOLD hold-off whenever the stimulus asks for it.
  initial begin : result_sink
    int hold_left;
    int mode_left;
    int tick;
    sink_mode_t mode;
    out_ch.ready = 1'b0;
    hold_left = 0;
    mode_left = 0;
    tick = 0;
    mode = SINK_OPEN;
    forever begin
      @(negedge clk);
      tick++;
      if (mode_left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req <= 1'b0;
        hold_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          SINK_OPEN:   out_ch.ready <= 1'b1;
          SINK_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          SINK_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
          default:     out_ch.ready <= (tick % 3) != 0;
        endcase
      end
    end
  end

  // Offer one request and hold it until the block takes the beat. Between
  // bursts, drop valid for a random gap when gaps are enabled.
  task automatic send_request(input req_t req, input logic [7:0] scan,
                              input logic [7:0] ascii);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.scan_code  <= scan;
    in_ch.ascii_code <= ascii;
    do @(posedge clk); while (!in_ch.ready);
    sent_total++;
    sent_by_req[req]++;
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic wait_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    burst_left = 0;
  endtask

  function automatic logic [7:0] pick_ascii();
    return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
  endfunction

  // Make codes biased toward keys with special handling
  function automatic logic [7:0] pick_make_code();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom_range(SC_F1, SC_F10));
      1:       return $urandom_range(0, 1) ? SC_F11 : SC_F12;
      2, 3:    return 8'($urandom_range(SC_NAV_LO, SC_NAV_HI));
      4: begin
        case ($urandom_range(0, 2))
          0:       return SC_TAB;
          1:       return SC_BKSP;
          default: return SC_ENTER;
        endcase
      end
      5:       return 8'($urandom_range(SC_DIG_LO, SC_DIG_HI));
      6:       return SC_ESC;
      default: return 8'($urandom_range(0, 8'h7F));
    endcase
  endfunction

  // Well-formed typing: press some modifiers, strike a few keys (with the
  // odd extended prefix, release and read-back), then release the modifiers.
  task automatic type_sequence();
    logic [3:0] held;
    logic [7:0] code;
    held = ($urandom_range(0, 2) == 0) ? 4'h0 : 4'($urandom_range(0, 15));
    for (int i = 0; i < 4; i++)
      if (held[i]) send_request(REQ_SCAN, {1'b0, MOD_KEYS[i]}, pick_ascii());
    repeat ($urandom_range(1, 5)) begin
      code = pick_make_code();
      if ($urandom_range(0, 7) == 0) send_request(REQ_SCAN, EXT_PREFIX, 8'h00);
      send_request(REQ_SCAN, code, pick_ascii());
      if ($urandom_range(0, 1)) send_request(REQ_SCAN, code | 8'h80, pick_ascii());
      if ($urandom_range(0, 5) == 0)
        send_request($urandom_range(0, 1) ? REQ_TAKE : REQ_PEEK, 8'($urandom), 8'($urandom));
    end
    for (int i = 0; i < 4; i++)
      if (held[i]) send_request(REQ_SCAN, {1'b1, MOD_KEYS[i]}, pick_ascii());
    repeat ($urandom_range(0, 3)) send_request(REQ_TAKE, 8'($urandom), 8'($urandom));
  endtask

  // One request drawn from the weights of the current traffic mix
  task automatic random_request(input traffic_mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (roll < 70) send_request(REQ_INSERT, 8'($urandom), 8'($urandom));
        else if (roll < 85) send_request(REQ_TAKE, 8'($urandom), 8'($urandom));
        else send_request(REQ_SCAN, pick_make_code(), pick_ascii());
      end
      MIX_DRAIN: begin
        if (roll < 55) send_request(REQ_TAKE, 8'($urandom), 8'($urandom));
        else if (roll < 80) send_request(REQ_PEEK, 8'($urandom), 8'($urandom));
        else if (roll < 90) send_request(REQ_INSERT, 8'($urandom), 8'($urandom));
        else send_request(REQ_SCAN, pick_make_code(), pick_ascii());
      end
      default: send_request(req_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
    endcase
  endtask

  initial begin : stimulus
    traffic_mix_t mix;
    int phase_no;
    int phase_end;

    // every input known from time zero
    rst_n            = 1'b0;
    long_hold_req    = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = REQ_SCAN;
    in_ch.scan_code  = 8'h00;
    in_ch.ascii_code = 8'h00;
    sent_total = 0;
    burst_left = 0;
    gaps_on    = 1'b1;
    idle_cycles = 0;
    phase_no   = 0;
    for (int i = 0; i < 4; i++) sent_by_req[i] = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < OPENING_LEN; i++)
      send_request(req_t'(OPENING_SEQ[i][17:16]), OPENING_SEQ[i][15:8], OPENING_SEQ[i][7:0]);
    wait_until_drained();

    // Random phases, each with its own traffic mix. A few phases open with
    // a long sink hold-off while the sender keeps pushing back to back, so
    // the block fills and drops its request ready.
    while (sent_total < ITEM_TARGET) begin
      mix = traffic_mix_t'($urandom_range(0, 3));
      gaps_on = ($urandom_range(0, 3) != 0);
      if (phase_no == 2 || phase_no == 7 || $urandom_range(0, 9) == 0) begin
        long_hold_req <= 1'b1;
        gaps_on = 1'b0;
      end
      phase_end = sent_total + $urandom_range(30, 140);
      // keep the last phase from running far past the target
      if (phase_end > ITEM_TARGET) phase_end = ITEM_TARGET;
      while (sent_total < phase_end) begin
        if (mix == MIX_TYPING) type_sequence();
        else random_request(mix);
      end
      // settle fully now and then, and at least once
      if (phase_no == 4 || $urandom_range(0, 2) == 0) wait_until_drained();
      phase_no++;
    end

    wait_until_drained();
    repeat (LATENCY_TAIL) @(negedge clk);

    $display("Run: %0d requests (%0d scan codes, %0d takes, %0d peeks, %0d inserts)",
             sent_total, sent_by_req[REQ_SCAN], sent_by_req[REQ_TAKE],
             sent_by_req[REQ_PEEK], sent_by_req[REQ_INSERT]);
    $display("Run: %0d results checked, %0d key words stored, %0d dropped on a full ring",
             checked_count, stored_count, drop_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
